FILE: hw/rtl/stfd_pkg.sv
// shared types and constants for the stuffed telemetry frame decoder
package stfd_pkg;

    localparam logic [7:0] START_MARK    = 8'h7E;
    localparam logic [7:0] ESC_MARK      = 8'h7D;
    localparam logic [7:0] ESC_XOR       = 8'h20;
    localparam logic [7:0] TYPE_LINK     = 8'hFE;
    localparam logic [7:0] TYPE_USER     = 8'hFD;
    localparam logic [7:0] TYPE_ALARM_HI = 8'hFC;
    localparam logic [7:0] TYPE_ALARM_LO = 8'hF9;

    localparam int         CNT_W           = 3;
    localparam logic [2:0] USER_COUNT_MASK = 3'h7;
    localparam int         MAX_USER        = 6;

    typedef enum logic [1:0] {
        KIND_LINK  = 2'd0,
        KIND_USER  = 2'd1,
        KIND_ALARM = 2'd2
    } kind_t;

    // one decoded frame waiting to be emitted
    typedef struct packed {
        kind_t                        kind;
        logic [1:0]                   slot;
        logic [7:0]                   a;
        logic [7:0]                   b;
        logic [7:0]                   c;
        logic [CNT_W-1:0]             count;
        logic [MAX_USER-1:0][7:0]     user;
    } cmd_t;

endpackage

FILE: hw/rtl/stfd_front.sv
// front end: byte unstuffing, frame assembly and frame classification
module stfd_front #(
    parameter int FRAME_BYTES = 10
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_wr_en,
    input  logic          cfg_wr_data,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    rx_byte,
    input  logic          q_full,
    output logic          push,
    output stfd_pkg::cmd_t cmd
);
    import stfd_pkg::*;

    localparam int IDX_W      = $clog2(FRAME_BYTES);
    localparam int POS_W      = $clog2(FRAME_BYTES + 1);
    localparam int USER_LIMIT = (FRAME_BYTES - 4 < MAX_USER) ? FRAME_BYTES - 4 : MAX_USER;

    logic [FRAME_BYTES-1:0][7:0] store_reg, store_next;
    logic [IDX_W-1:0]            pos_reg, pos_next;
    logic                        esc_reg, esc_next;
    logic                        alarms_enable_reg;

    logic                        accept;
    logic [IDX_W-1:0]            pos_idx;
    logic [POS_W-1:0]            pos_n;
    logic                        is_start;
    logic [7:0]                  wr_val;
    logic                        frame_done;
    logic [7:0]                  typ;
    logic [7:0]                  slot_diff;
    logic [CNT_W-1:0]            cnt_raw;
    logic [CNT_W-1:0]            cnt;
    logic                        has_result;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        // an out-of-range position is taken as the start of the frame
        pos_idx    = (POS_W'(pos_reg) >= POS_W'(FRAME_BYTES)) ? '0 : pos_reg;
        is_start   = (rx_byte == START_MARK);
        wr_val     = (esc_reg && !is_start) ? (rx_byte ^ ESC_XOR) : rx_byte;
        store_next = store_reg;
        esc_next   = esc_reg;
        pos_n      = POS_W'(pos_idx);
        pos_next   = pos_reg;
        frame_done = 1'b0;
        if (accept)
        begin
            store_next[pos_idx] = wr_val;
            // start mark leaves a pending escape in place
            if (is_start)
            begin
                store_next[0] = START_MARK;
                pos_n         = POS_W'(1);
            end
            else if (esc_reg)
            begin
                esc_next = 1'b0;
                pos_n    = POS_W'(pos_idx) + POS_W'(1);
            end
            else if (rx_byte == ESC_MARK)
            begin
                esc_next = 1'b1;
            end
            else
            begin
                pos_n = POS_W'(pos_idx) + POS_W'(1);
            end
            if (store_next[0] != START_MARK)
            begin
                pos_n = '0;
            end
            else if (pos_n == POS_W'(FRAME_BYTES))
            begin
                frame_done = 1'b1;
                pos_n      = '0;
            end
            pos_next = pos_n[IDX_W-1:0];
        end
    end

    // classify the completed frame
    always_comb
    begin
        typ       = store_next[1];
        slot_diff = TYPE_ALARM_HI - typ;
        cnt_raw   = store_next[2][CNT_W-1:0] & USER_COUNT_MASK;
        cnt       = (cnt_raw > CNT_W'(USER_LIMIT)) ? CNT_W'(USER_LIMIT) : cnt_raw;

        cmd       = '0;
        cmd.a     = store_next[2];
        cmd.b     = store_next[3];
        cmd.c     = store_next[4];
        cmd.count = cnt;
        for (int i = 0; i < USER_LIMIT; i++)
        begin
            cmd.user[i] = store_next[i + 4];
        end

        if (typ == TYPE_LINK)
        begin
            cmd.kind   = KIND_LINK;
            has_result = 1'b1;
        end
        else if (typ == TYPE_USER)
        begin
            cmd.kind   = KIND_USER;
            cmd.b      = '0;
            cmd.c      = '0;
            has_result = (cnt != '0);
        end
        else if (typ >= TYPE_ALARM_LO && typ <= TYPE_ALARM_HI)
        begin
            cmd.kind   = KIND_ALARM;
            cmd.slot   = slot_diff[1:0];
            has_result = alarms_enable_reg;
        end
        else
        begin
            cmd.kind   = KIND_LINK;
            has_result = 1'b0;
        end
        push = frame_done && has_result;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            store_reg         <= '0;
            pos_reg           <= '0;
            esc_reg           <= 1'b0;
            alarms_enable_reg <= 1'b0;
        end
        else
        begin
            store_reg <= store_next;
            pos_reg   <= pos_next;
            esc_reg   <= esc_next;
            if (cfg_wr_en)
            begin
                alarms_enable_reg <= cfg_wr_data;
            end
        end
    end

`ifndef SYNTH
    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        POS_W'(pos_reg) < POS_W'(FRAME_BYTES))
        else $error("write position out of range");

    a_hunt_resets_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && store_next[0] != START_MARK) |=> (pos_reg == '0))
        else $error("position not cleared while hunting for start");
`endif

endmodule

FILE: hw/rtl/stfd_queue.sv
// two-entry queue of decoded frames between front and back
module stfd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  stfd_pkg::cmd_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output stfd_pkg::cmd_t pop_data
);
    import stfd_pkg::*;

    cmd_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;

    assign full     = (cnt_reg == 2'd2);
    assign valid    = (cnt_reg != 2'd0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("frame queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !valid))
        else $error("frame queue underflow");
`endif

endmodule

FILE: hw/rtl/stfd_back.sv
// back end: turns queued frames into result items through an output register
module stfd_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  stfd_pkg::cmd_t q_data,
    output logic           q_pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [1:0]     kind,
    output logic [1:0]     alarm_slot,
    output logic [7:0]     value_a,
    output logic [7:0]     value_b,
    output logic [7:0]     value_c,
    output logic           last
);
    import stfd_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t     state_reg, state_next;
    cmd_t       work_reg, work_next;
    logic       out_valid_reg, out_valid_next;
    kind_t      kind_reg, kind_next;
    logic [1:0] slot_reg, slot_next;
    logic [7:0] a_reg, a_next;
    logic [7:0] b_reg, b_next;
    logic [7:0] c_reg, c_next;
    logic       last_reg, last_next;

    logic       out_load;
    logic       is_last;

    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign alarm_slot = slot_reg;
    assign value_a    = a_reg;
    assign value_b    = b_reg;
    assign value_c    = c_reg;
    assign last       = last_reg;

    always_comb
    begin
        out_load       = !out_valid_reg || out_ready;
        is_last        = (work_reg.kind != KIND_USER) || (work_reg.count == CNT_W'(1));
        q_pop          = (state_reg == ST_IDLE) && q_valid;

        state_next     = state_reg;
        work_next      = work_reg;
        out_valid_next = out_valid_reg && !out_ready;
        kind_next      = kind_reg;
        slot_next      = slot_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        last_next      = last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    work_next  = q_data;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = work_reg.kind;
                    slot_next      = work_reg.slot;
                    a_next         = (work_reg.kind == KIND_USER) ? work_reg.user[0]
                                                                  : work_reg.a;
                    b_next         = work_reg.b;
                    c_next         = work_reg.c;
                    last_next      = is_last;
                    if (is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        // next user byte moves to the head
                        work_next.count = work_reg.count - CNT_W'(1);
                        work_next.user  = {8'h00, work_reg.user[MAX_USER-1:1]};
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            work_reg      <= '0;
            out_valid_reg <= 1'b0;
            kind_reg      <= KIND_LINK;
            slot_reg      <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            c_reg         <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            work_reg      <= work_next;
            out_valid_reg <= out_valid_next;
            kind_reg      <= kind_next;
            slot_reg      <= slot_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            c_reg         <= c_next;
            last_reg      <= last_next;
        end
    end

`ifndef SYNTH
    a_user_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && work_reg.kind == KIND_USER) |-> (work_reg.count != '0))
        else $error("user run with no bytes left");
`endif

endmodule

FILE: hw/rtl/stuffed_telemetry_frame_decoder_top.sv
// top level of the stuffed telemetry frame decoder
//
//  channel | signals                                          | dir | handshake
//  --------+--------------------------------------------------+-----+--------------------
//  in      | rx_byte                                          | in  | in_valid / in_ready
//  out     | kind alarm_slot value_a value_b value_c last     | out | out_valid / out_ready
//  cfg     | cfg_wr_data (alarms enable)                      | in  | cfg_wr_en, no wait
//
// one byte is taken per cycle while the two-entry frame queue has room
// a completed frame with results is queued; the back end emits one result per cycle
// while out_ready is high, after taking each queued frame from the queue in its idle state
// reset clears the frame store, write position, escape flag, queue and alarms enable
// out_ready low holds the result register; a full queue drops in_ready

module stuffed_telemetry_frame_decoder_top #(
    parameter int FRAME_BYTES = 10
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] kind,
    output logic [1:0] alarm_slot,
    output logic [7:0] value_a,
    output logic [7:0] value_b,
    output logic [7:0] value_c,
    output logic       last
);
    import stfd_pkg::*;

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_valid;
    cmd_t push_cmd;
    cmd_t pop_cmd;

    stfd_front #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_byte     (rx_byte),
        .q_full      (q_full),
        .push        (q_push),
        .cmd         (push_cmd)
    );

    stfd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (pop_cmd)
    );

    stfd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_data     (pop_cmd),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .alarm_slot (alarm_slot),
        .value_a    (value_a),
        .value_b    (value_b),
        .value_c    (value_c),
        .last       (last)
    );

endmodule

FILE: verif/tb_top.sv
// self-checking testbench for the stuffed telemetry frame decoder
module tb_top;
    import stfd_pkg::*;

    localparam int FRAME_BYTES = 10;
    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD   = 240;
    localparam int SETTLE      = 16;
    localparam logic [7:0] CORNER_BYTES [6] = '{8'h7E, 8'h7D, 8'h00, 8'hFF, 8'h5E, 8'h5D};

    typedef struct packed {
        kind_t      kind;
        logic [1:0] slot;
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
        logic       last;
    } telem_result_t;

    typedef struct {
        logic [7:0]    data;
        bit            typed;
        telem_result_t want;
    } stim_row_t;

    localparam telem_result_t NO_RESULT = '{KIND_LINK, 2'd0, 8'd0, 8'd0, 8'd0, 1'b0};

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic       cfg_wr_data = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] rx_byte = 8'd0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [1:0] kind;
    logic [1:0] alarm_slot;
    logic [7:0] value_a;
    logic [7:0] value_b;
    logic [7:0] value_c;
    logic       last;

    // predictor state
    logic [7:0]    rx_frame [FRAME_BYTES];
    int            wr_pos;
    bit            esc_pending;
    bit            alarms_on;
    telem_result_t pending_results [$];

    int  framed_items;
    int  link_frames;
    int  user_bytes;
    int  alarm_frames;
    int  silent_frames;
    int  results_checked;
    int  errors;
    bit  calm;
    bit  hold_req;
    stim_row_t directed_rows [25];

    stuffed_telemetry_frame_decoder_top #(
        .FRAME_BYTES(FRAME_BYTES)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .alarm_slot (alarm_slot),
        .value_a    (value_a),
        .value_b    (value_b),
        .value_c    (value_c),
        .last       (last)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("mismatch on %s at %0t: got %0h expected %0h", field, $time, got, want);
        errors++;
    endtask

    // one received byte through the deframer, expected results queued
    function automatic void deframe_byte(input logic [7:0] data);
        int            pos;
        int            n;
        telem_result_t r;
        pos = wr_pos;
        if (pos >= FRAME_BYTES)
            pos = 0;
        rx_frame[pos] = data;
        if (data == START_MARK)
        begin
            // a start mark leaves a pending escape alone
            rx_frame[0] = START_MARK;
            pos = 1;
        end
        else if (esc_pending)
        begin
            rx_frame[pos] = data ^ ESC_XOR;
            esc_pending = 1'b0;
            pos++;
        end
        else if (data == ESC_MARK)
            esc_pending = 1'b1;
        else
            pos++;

        if (rx_frame[0] != START_MARK)
            pos = 0;
        else if (pos == FRAME_BYTES)
        begin
            pos = 0;
            r = NO_RESULT;
            r.a = rx_frame[2];
            r.b = rx_frame[3];
            r.c = rx_frame[4];
            r.last = 1'b1;
            if (rx_frame[1] == TYPE_LINK)
            begin
                pending_results.push_back(r);
                link_frames++;
            end
            else if (rx_frame[1] == TYPE_USER)
            begin
                n = int'(rx_frame[2][2:0] & USER_COUNT_MASK);
                if (n > FRAME_BYTES - 4)
                    n = FRAME_BYTES - 4;
                if (n > MAX_USER)
                    n = MAX_USER;
                if (n == 0)
                    silent_frames++;
                for (int i = 0; i < n; i++)
                begin
                    r.kind = KIND_USER;
                    r.a = rx_frame[4 + i];
                    r.b = 8'd0;
                    r.c = 8'd0;
                    r.last = (i == n - 1);
                    pending_results.push_back(r);
                    user_bytes++;
                end
            end
            else if (rx_frame[1] >= TYPE_ALARM_LO && rx_frame[1] <= TYPE_ALARM_HI && alarms_on)
            begin
                r.kind = KIND_ALARM;
                r.slot = 2'(TYPE_ALARM_HI - rx_frame[1]);
                pending_results.push_back(r);
                alarm_frames++;
            end
            else
                silent_frames++;
        end
        wr_pos = pos;
        if (rx_frame[0] == START_MARK)
            framed_items++;
    endfunction

    task automatic offer_item(input logic [7:0] data);
        if (!calm && $urandom_range(0, 9) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= data;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic feed_byte(input logic [7:0] data);
        offer_item(data);
        deframe_byte(data);
    endtask

    // a frame of len bytes with random type and payload, stuffed where needed and at random
    task automatic send_frame(input int len);
        logic [7:0] data;
        int         pick;
        feed_byte(START_MARK);
        for (int i = 1; i < len; i++)
        begin
            if (i == 1)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 3)
                    data = TYPE_LINK;
                else if (pick < 6)
                    data = TYPE_USER;
                else if (pick < 9)
                    data = TYPE_ALARM_LO + 8'($urandom_range(0, 3));
                else
                    data = 8'($urandom);
            end
            else if ($urandom_range(0, 5) == 0)
                data = CORNER_BYTES[$urandom_range(0, 5)];
            else
                data = 8'($urandom);
            // an escaped 0x5e would go out as a start mark
            if (data == START_MARK || data == ESC_MARK ||
                (data != 8'h5E && $urandom_range(0, 9) == 0))
            begin
                feed_byte(ESC_MARK);
                feed_byte(data ^ ESC_XOR);
            end
            else
                feed_byte(data);
        end
    endtask

    task automatic send_random_chunk();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 15)
            send_frame(FRAME_BYTES);
        else if (pick < 17)
            send_frame($urandom_range(2, FRAME_BYTES - 1));
        else if (pick < 19)
            repeat ($urandom_range(1, 6)) feed_byte(8'($urandom));
        else
        begin
            // escape still pending when the start mark arrives
            feed_byte(ESC_MARK);
            send_frame(FRAME_BYTES);
        end
    endtask

    task automatic settle_block();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_alarms_enable(input logic value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        alarms_on = value;
    endtask

    // result side: checks each item and stalls in bursts
    initial
    begin
        int            stall_left;
        telem_result_t want;
        stall_left = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                results_checked++;
                if (pending_results.size() == 0)
                    report_mismatch("unexpected result kind", kind, 0);
                else
                begin
                    want = pending_results.pop_front();
                    if (kind != want.kind)
                        report_mismatch("kind", kind, want.kind);
                    if (alarm_slot != want.slot)
                        report_mismatch("alarm_slot", alarm_slot, want.slot);
                    if (value_a != want.a)
                        report_mismatch("value_a", value_a, want.a);
                    if (value_b != want.b)
                        report_mismatch("value_b", value_b, want.b);
                    if (value_c != want.c)
                        report_mismatch("value_c", value_c, want.c);
                    if (last != want.last)
                        report_mismatch("last", last, want.last);
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req = 1'b0;
                stall_left = LONG_HOLD - 1;
                out_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 12);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // no item moving on either side for too long ends the run
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: %0d cycles with no item moving, %0d results outstanding",
                 STALL_LIMIT, pending_results.size());
        $display("FAIL stuffed_telemetry_frame_decoder_top");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < FRAME_BYTES; i++)
            rx_frame[i] = 8'd0;
        wr_pos = 0;
        esc_pending = 1'b0;
        alarms_on = 1'b0;

        // escape while hunting turns 0x5e into a start, start mark during escape,
        // an escaped 0x7d and a doubled 0x7d, then a user frame whose count of 7 clamps to 6
        directed_rows = '{
            '{8'h7D, 1'b0, NO_RESULT}, '{8'h5E, 1'b0, NO_RESULT},
            '{8'h7D, 1'b0, NO_RESULT}, '{8'h7E, 1'b0, NO_RESULT},
            '{8'hDE, 1'b0, NO_RESULT}, '{8'h7D, 1'b0, NO_RESULT},
            '{8'h5D, 1'b0, NO_RESULT}, '{8'hFF, 1'b0, NO_RESULT},
            '{8'h00, 1'b0, NO_RESULT}, '{8'h7D, 1'b0, NO_RESULT},
            '{8'h7D, 1'b0, NO_RESULT}, '{8'h11, 1'b0, NO_RESULT},
            '{8'h22, 1'b0, NO_RESULT}, '{8'h33, 1'b0, NO_RESULT},
            '{8'h44, 1'b1, '{KIND_LINK, 2'd0, 8'h7D, 8'hFF, 8'h00, 1'b1}},
            '{8'h7E, 1'b0, NO_RESULT}, '{8'hFD, 1'b0, NO_RESULT},
            '{8'h07, 1'b0, NO_RESULT}, '{8'hFF, 1'b0, NO_RESULT},
            '{8'h00, 1'b0, NO_RESULT}, '{8'hFF, 1'b0, NO_RESULT},
            '{8'h01, 1'b0, NO_RESULT}, '{8'h80, 1'b0, NO_RESULT},
            '{8'h7F, 1'b0, NO_RESULT}, '{8'h55, 1'b0, NO_RESULT}
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < 25; i++)
        begin
            if (directed_rows[i].typed)
            begin
                offer_item(directed_rows[i].data);
                deframe_byte(directed_rows[i].data);
                void'(pending_results.pop_back());
                pending_results.push_back(directed_rows[i].want);
            end
            else
                feed_byte(directed_rows[i].data);
        end

        // alarms off from reset
        while (framed_items < 96)
            send_random_chunk();
        settle_block();

        // alarms on, with a long result stall to back up the input
        write_alarms_enable(1'b1);
        hold_req = 1'b1;
        while (framed_items < 167)
            send_random_chunk();
        settle_block();

        write_alarms_enable(1'b0);
        while (framed_items < 238)
            send_random_chunk();
        settle_block();

        // last stretch at full rate on both sides
        write_alarms_enable(1'b1);
        calm = 1'b1;
        while (framed_items < 310)
            send_random_chunk();

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("covered %0d framed bytes: %0d link frames, %0d user bytes, %0d alarm frames,",
                 framed_items, link_frames, user_bytes, alarm_frames);
        $display("%0d frames with no output, %0d results checked, %0d mismatches",
                 silent_frames, results_checked, errors);
        if (errors == 0)
            $display("PASS stuffed_telemetry_frame_decoder_top");
        else
            $display("FAIL stuffed_telemetry_frame_decoder_top");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/stfd_pkg.sv
hw/rtl/stfd_front.sv
hw/rtl/stfd_queue.sv
hw/rtl/stfd_back.sv
hw/rtl/stuffed_telemetry_frame_decoder_top.sv
verif/tb_top.sv
